@@ hdl/erd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_pkg: escape RLE decompressor shared definitions
// Field widths, marker constants, register indexes and error codes.
// ----------------------------------------------------------------------------
package erd_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 28;
   localparam int SIZE_W     = 24;
   localparam int GROUP_W    = 7;
   localparam int ERR_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [BYTE_W-1:0]  ESC_MARK   = 8'h80;
   localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7f;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SIZE  = 2'd1;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_COUNT_ONE = 3'd1,
      ERR_NO_BYTE   = 3'd2,
      ERR_TOO_LONG  = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } err_type;

endpackage

@@ hdl/erd_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_req_if: compressed byte channel
// One compressed byte per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface erd_req_if import erd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

@@ hdl/erd_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_rsp_if: decoded run channel
// One value with its repeat count and status per transaction.
// ----------------------------------------------------------------------------
interface erd_rsp_if import erd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  value;
   logic [COUNT_W-1:0] repeat_res;
   logic               done_res;
   logic [ERR_W-1:0]   error;

   modport source (output valid, output value, output repeat_res, output done_res,
                   output error, input ready);
   modport sink   (input valid, input value, input repeat_res, input done_res,
                   input error, output ready);
endinterface

@@ hdl/erd_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_csr_if: register write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface erd_csr_if import erd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/escape_rle_decompressor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_rle_decompressor_core: escape-marker run-length decoder
// Decodes one compressed byte per cycle, unless rsp_if stalls, into (value, repeat) results with
// a raw prefix, multi-group counts, sticky errors and a target output size.
// ----------------------------------------------------------------------------
//   channel   direction  contents
//   req_if    in         in_byte
//   rsp_if    out        value, repeat_res, done_res, error
//   csr_if    in         index (0 prefix_bytes, 1 target_size), data
//
// One byte per cycle sustained unless rsp_if stalls; a byte passes the input
// register, then the result register, with the single decode step between them.
// Synchronous reset clears all decoder state and the registers to defaults.
// A stalled result register holds the input register, which holds req_if.
// Markers, non-final count bytes, and bytes after done or an error give no result.
// ----------------------------------------------------------------------------
module escape_rle_decompressor_core
   import erd_pkg::*;
#(
   parameter int MAX_COUNT_GROUPS = 4
) (
   input  logic     clock,
   input  logic     reset,
   erd_req_if.sink  req_if,
   erd_rsp_if.source rsp_if,
   erd_csr_if.sink  csr_if
);

   localparam int GI_W = $clog2(MAX_COUNT_GROUPS + 1);
   localparam int SH_W = GI_W + 3;

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_LITERAL = 2'd1,
      PH_COUNT   = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   // configuration
   logic [BYTE_W-1:0]  prefix_bytes_ff, prefix_bytes_in;
   logic [SIZE_W-1:0]  target_size_ff, target_size_in;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]  s1_byte_ff, s1_byte_in;

   // decoder state
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_accum_ff, count_accum_in;
   logic [GI_W-1:0]    group_index_ff, group_index_in;
   logic [BYTE_W-1:0]  held_byte_ff, held_byte_in;
   logic               held_valid_ff, held_valid_in;
   logic [SIZE_W-1:0]  produced_ff, produced_in;
   logic [BYTE_W-1:0]  prefix_seen_ff, prefix_seen_in;
   err_type            sticky_error_ff, sticky_error_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_repeat_ff, rsp_repeat_in;
   logic               rsp_done_ff, rsp_done_in;
   err_type            rsp_error_ff, rsp_error_in;

   logic               out_free;
   logic               s1_fire;
   logic               res_fire;
   logic               emit_req;
   logic [BYTE_W-1:0]  emit_val;
   logic [COUNT_W-1:0] emit_n;
   logic               err_req;
   err_type            err_code;
   logic [COUNT_W:0]   emit_total;
   logic               emit_done;
   logic [SH_W-1:0]    grp_shift;
   logic [COUNT_W-1:0] grp_bits;
   logic [COUNT_W-1:0] accum_new;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire       = s1_valid_ff && out_free;
   assign req_if.ready  = !s1_valid_ff || s1_fire;
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.value      = rsp_value_ff;
   assign rsp_if.repeat_res = rsp_repeat_ff;
   assign rsp_if.done_res   = rsp_done_ff;
   assign rsp_if.error      = rsp_error_ff;

   // 7 * group_index, then place the group; shifts past the count width drop out
   assign grp_shift = {group_index_ff, 3'b000} - {3'b000, group_index_ff};
   assign grp_bits  = {{(COUNT_W - GROUP_W){1'b0}}, s1_byte_ff[GROUP_W-1:0] & GROUP_MASK}
                      << grp_shift;
   assign accum_new = count_accum_ff | grp_bits;

   always_comb begin
      prefix_bytes_in = prefix_bytes_ff;
      target_size_in  = target_size_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_PREFIX_BYTES: prefix_bytes_in = csr_if.data[BYTE_W-1:0];
            CSR_TARGET_SIZE:  target_size_in  = csr_if.data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_if.valid && req_if.ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_if.in_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      count_accum_in  = count_accum_ff;
      group_index_in  = group_index_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      produced_in     = produced_ff;
      prefix_seen_in  = prefix_seen_ff;
      sticky_error_in = sticky_error_ff;
      emit_req        = 1'b0;
      emit_val        = '0;
      emit_n          = '0;
      err_req         = 1'b0;
      err_code        = ERR_NONE;
      emit_total      = '0;
      emit_done       = 1'b0;
      res_fire        = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_repeat_in   = rsp_repeat_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_error_in    = rsp_error_ff;

      if (s1_fire && sticky_error_ff == ERR_NONE && phase_ff != PH_DONE) begin
         if (phase_ff == PH_PREFIX && prefix_seen_ff < prefix_bytes_ff) begin
            prefix_seen_in = prefix_seen_ff + 1'b1;
            emit_req       = 1'b1;
            emit_val       = s1_byte_ff;
            emit_n         = COUNT_W'(1);
         end else if (phase_ff == PH_PREFIX || phase_ff == PH_LITERAL) begin
            if (s1_byte_ff == ESC_MARK) begin
               phase_in       = PH_COUNT;
               count_accum_in = '0;
               group_index_in = '0;
            end else begin
               phase_in      = PH_LITERAL;
               held_byte_in  = s1_byte_ff;
               held_valid_in = 1'b1;
               emit_req      = 1'b1;
               emit_val      = s1_byte_ff;
               emit_n        = COUNT_W'(1);
            end
         end else if (group_index_ff >= GI_W'(MAX_COUNT_GROUPS)) begin
            err_req  = 1'b1;
            err_code = ERR_TOO_LONG;
         end else begin
            count_accum_in = accum_new;
            group_index_in = group_index_ff + 1'b1;
            if (s1_byte_ff[BYTE_W-1]) begin
               phase_in       = PH_LITERAL;
               group_index_in = '0;
               if (accum_new == '0) begin
                  emit_req = 1'b1;
                  emit_val = ESC_MARK;
                  emit_n   = COUNT_W'(1);
               end else if (accum_new == COUNT_W'(1)) begin
                  err_req  = 1'b1;
                  err_code = ERR_COUNT_ONE;
               end else if (!held_valid_ff) begin
                  err_req  = 1'b1;
                  err_code = ERR_NO_BYTE;
               end else begin
                  held_valid_in = 1'b0;
                  emit_req      = 1'b1;
                  emit_val      = held_byte_ff;
                  emit_n        = accum_new - 1'b1;
               end
            end
         end

         if (emit_req) begin
            emit_total = {{(COUNT_W - SIZE_W + 1){1'b0}}, produced_ff} + {1'b0, emit_n};
            if (emit_total > {{(COUNT_W - SIZE_W + 1){1'b0}}, target_size_ff}) begin
               err_req  = 1'b1;
               err_code = ERR_OVERFLOW;
            end else begin
               produced_in = emit_total[SIZE_W-1:0];
               emit_done   = (emit_total[SIZE_W-1:0] == target_size_ff)
                             && (prefix_seen_in >= prefix_bytes_ff);
               if (emit_done) begin
                  phase_in = PH_DONE;
               end
               res_fire      = 1'b1;
               rsp_value_in  = emit_val;
               rsp_repeat_in = emit_n;
               rsp_done_in   = emit_done;
               rsp_error_in  = ERR_NONE;
            end
         end

         if (err_req) begin
            sticky_error_in = err_code;
            res_fire        = 1'b1;
            rsp_value_in    = '0;
            rsp_repeat_in   = '0;
            rsp_done_in     = 1'b0;
            rsp_error_in    = err_code;
         end
      end

      if (res_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_bytes_ff <= '0;
         target_size_ff  <= '1;
         s1_valid_ff     <= 1'b0;
         s1_byte_ff      <= '0;
         phase_ff        <= PH_PREFIX;
         count_accum_ff  <= '0;
         group_index_ff  <= '0;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         produced_ff     <= '0;
         prefix_seen_ff  <= '0;
         sticky_error_ff <= ERR_NONE;
         rsp_valid_ff    <= 1'b0;
         rsp_value_ff    <= '0;
         rsp_repeat_ff   <= '0;
         rsp_done_ff     <= 1'b0;
         rsp_error_ff    <= ERR_NONE;
      end else begin
         prefix_bytes_ff <= prefix_bytes_in;
         target_size_ff  <= target_size_in;
         s1_valid_ff     <= s1_valid_in;
         s1_byte_ff      <= s1_byte_in;
         phase_ff        <= phase_in;
         count_accum_ff  <= count_accum_in;
         group_index_ff  <= group_index_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         produced_ff     <= produced_in;
         prefix_seen_ff  <= prefix_seen_in;
         sticky_error_ff <= sticky_error_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_value_ff    <= rsp_value_in;
         rsp_repeat_ff   <= rsp_repeat_in;
         rsp_done_ff     <= rsp_done_in;
         rsp_error_ff    <= rsp_error_in;
      end
   end

   // once an error is latched, no further result is produced
   a_sticky_silent: assert property (@(posedge clock) disable iff (reset)
      (sticky_error_ff != ERR_NONE) |-> !res_fire)
      else $error("result produced after sticky error");

   // nothing comes out after done
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> !res_fire)
      else $error("result produced after done");

   // a done result moves the decoder to its final phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      (res_fire && rsp_done_in) |=> (phase_ff == PH_DONE))
      else $error("done result without done phase");

   // group counter never runs past the group limit
   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      group_index_ff <= GI_W'(MAX_COUNT_GROUPS))
      else $error("count group index out of range");

   // a stalled result must not be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !res_fire)
      else $error("pending result overwritten");

endmodule
